### hw/rtl/mips_itype_execute_core_assert.svh
// assertion macros for the i-type execute core
// no dependencies; included by the top level
`ifndef MIPS_ITYPE_EXECUTE_CORE_ASSERT_SVH
`define MIPS_ITYPE_EXECUTE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define MITE_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mite implication check failed");
`define MITE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mite next-cycle check failed");
`else
`define MITE_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define MITE_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

### hw/rtl/mite_pkg.sv
// opcodes, shared structs and a sign-extension function of the i-type execute core
// no dependencies
package mite_pkg;

    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_XORI  = 6'h0E;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LH    = 6'h21;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LBU   = 6'h24;
    localparam logic [5:0] OP_LHU   = 6'h25;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2B;

    localparam logic [4:0] REG_ZERO = 5'd0;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [7:0] wdata;
    } mem_cmd_t;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        sext16 = {{16{v[15]}}, v};
    endfunction

endpackage

### hw/rtl/mite_regfile.sv
// 32 x 32 register file, two registered read ports, one write port
// per-entry valid bits give the all-zero reset; uses mite_pkg
module mite_regfile (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [4:0]       rd_addr_a,
    input  logic [4:0]       rd_addr_b,
    output logic [31:0]      rd_data_a,
    output logic [31:0]      rd_data_b,
    input  mite_pkg::rf_wr_t wr
);
    import mite_pkg::*;

    logic [31:0] mem [32];
    logic [31:0] valid_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en && wr.idx != REG_ZERO) begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && wr.idx != REG_ZERO) begin
            mem[wr.idx] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= valid_reg[rd_addr_a] ? mem[rd_addr_a] : '0;
            rd_b_reg <= valid_reg[rd_addr_b] ? mem[rd_addr_b] : '0;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### hw/rtl/mite_dmem.sv
// byte-wide data memory with registered read and a clearing pass after reset
// uses mite_pkg
module mite_dmem #(
    parameter int MEM_BYTES = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mite_pkg::mem_cmd_t           cmd,
    input  logic [$clog2(MEM_BYTES)-1:0] addr,
    output logic [7:0]                   rd_data,
    output logic                         busy
);
    import mite_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);

    logic [7:0]    mem [MEM_BYTES];
    logic [AW-1:0] clr_cnt_reg;
    logic          busy_reg;
    logic [7:0]    rd_data_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (busy_reg) begin
            if (clr_cnt_reg == MEM_LAST) begin
                busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign we    = busy_reg || cmd.wr;
    assign waddr = busy_reg ? clr_cnt_reg : addr;
    assign wdata = busy_reg ? 8'h00 : cmd.wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

### hw/rtl/mite_alu.sv
// shared alu: immediate arithmetic, logic, compares and effective address
// uses mite_pkg
module mite_alu (
    input  logic [5:0]  op,
    input  logic [31:0] a,
    input  logic [15:0] imm,
    output logic [31:0] result
);
    import mite_pkg::*;

    logic [31:0] simm;
    logic [31:0] zimm;

    assign simm = sext16(imm);
    assign zimm = {16'h0000, imm};

    always_comb begin
        case (op)
            OP_SLTI:  result = {31'd0, $signed(a) < $signed(simm)};
            OP_SLTIU: result = {31'd0, a < simm};
            OP_ANDI:  result = a & zimm;
            OP_ORI:   result = a | zimm;
            OP_XORI:  result = a ^ zimm;
            OP_LUI:   result = {imm, 16'h0000};
            // addi, addiu and load/store effective address
            default:  result = a + simm;
        endcase
    end

endmodule

### hw/rtl/mips_itype_execute_core.sv
// top level of the i-type execute core: sequencer, address reduction, output register
// uses mite_pkg, mite_regfile, mite_dmem, mite_alu and the assertion header
//
//  port group   dir  tdata fields (low bit up)                                  tuser
//  s_*          in   instruction_word[31:0], current_pc[63:32]                   -
//  m_*          out  next_pc, branch_taken, dest_written, dest_index, dest_value  illegal_opcode
//
//  alu ops, branches, illegal opcodes: accept, execute, writeback
//  loads, stores: one byte per cycle on the single memory port, plus a load wait for loads
//  MEM_BYTES not a power of two adds reciprocal address reduction per load or store
//  after reset the data memory is cleared byte by byte with s_tready low
//  writeback holds while a previous result waits in the output register
module mips_itype_execute_core #(
    parameter int MEM_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // instruction_word, current_pc
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // next_pc, branch_taken, dest_written, dest_index, dest_value
    output logic        m_tuser    // illegal_opcode
);
    import mite_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int FL = $clog2(MEM_BYTES + 1) - 1;
    localparam int MOD_SHIFT = 32 + FL;
    localparam bit MEM_POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
    localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);
    localparam logic [63:0] MOD_MUL_FULL = (64'd1 << MOD_SHIFT) / 64'(MEM_BYTES);
    localparam logic [31:0] MOD_MUL = 32'(MOD_MUL_FULL);
    localparam logic [31:0] MOD_DIV = 32'(MEM_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_MEM   = 3'd3;
    localparam logic [2:0] S_LWAIT = 3'd4;
    localparam logic [2:0] S_WB    = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [5:0]    op_reg;
    logic [4:0]    rt_reg;
    logic [15:0]   imm_reg;
    logic [31:0]   pc4_reg;
    logic [31:0]   npc_reg, npc_next;
    logic          taken_reg, taken_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   ea_reg, ea_next;
    logic [31:0]   mod_reg, mod_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [31:0]   b_reg, b_next;
    logic [1:0]    k_reg, k_next;
    logic [1:0]    step_reg, step_next;
    logic          rd_pend_reg;
    logic [1:0]    rd_k_reg;
    logic [31:0]   ld_reg;
    logic          m_tvalid_reg;
    logic [71:0]   m_tdata_reg;
    logic          m_tuser_reg;

    logic          accept;
    logic          mem_busy;
    logic [31:0]   rd_a;
    logic [31:0]   rd_b;
    logic [31:0]   alu_res;
    logic [7:0]    mem_rdata;
    rf_wr_t        rf_wr;
    mem_cmd_t      mem_cmd;
    logic          is_load, is_store, is_alu, is_branch, illegal;
    logic [1:0]    last_k;
    logic [63:0]   mod_prod;
    logic          out_free;
    logic          wr_en;
    logic [31:0]   wb_val;
    logic [31:0]   br_off;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !mem_busy;
    assign out_free = !m_tvalid_reg || m_tready;

    mite_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_a (s_tdata[25:21]),
        .rd_addr_b (s_tdata[20:16]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr        (rf_wr)
    );

    mite_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mem_cmd),
        .addr    (addr_reg),
        .rd_data (mem_rdata),
        .busy    (mem_busy)
    );

    mite_alu u_alu (
        .op     (op_reg),
        .a      (rd_a),
        .imm    (imm_reg),
        .result (alu_res)
    );

    always_comb begin
        is_load   = 1'b0;
        is_store  = 1'b0;
        is_alu    = 1'b0;
        is_branch = 1'b0;
        last_k    = 2'd0;
        case (op_reg)
            OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU,
            OP_ANDI, OP_ORI, OP_XORI, OP_LUI: is_alu = 1'b1;
            OP_BEQ, OP_BNE: is_branch = 1'b1;
            OP_LB, OP_LBU:  is_load = 1'b1;
            OP_LH, OP_LHU: begin
                is_load = 1'b1;
                last_k  = 2'd1;
            end
            OP_LW: begin
                is_load = 1'b1;
                last_k  = 2'd3;
            end
            OP_SB: is_store = 1'b1;
            OP_SH: begin
                is_store = 1'b1;
                last_k   = 2'd1;
            end
            OP_SW: begin
                is_store = 1'b1;
                last_k   = 2'd3;
            end
            default: ;
        endcase
    end

    assign illegal  = !(is_alu || is_branch || is_load || is_store);
    assign br_off   = {imm_reg[15], imm_reg[15], imm_reg[15], imm_reg[15], imm_reg[15],
                       imm_reg[15], imm_reg[15], imm_reg[15], imm_reg[15], imm_reg[15],
                       imm_reg[15], imm_reg[15], imm_reg[15], imm_reg[15], imm_reg, 2'b00};
    assign mod_prod = {32'd0, ea_reg} * {32'd0, MOD_MUL};

    // loaded bytes are formatted at writeback
    always_comb begin
        case (op_reg)
            OP_LB:   wb_val = {{24{ld_reg[7]}}, ld_reg[7:0]};
            OP_LBU:  wb_val = {24'd0, ld_reg[7:0]};
            OP_LH:   wb_val = sext16(ld_reg[15:0]);
            OP_LHU:  wb_val = {16'd0, ld_reg[15:0]};
            OP_LW:   wb_val = ld_reg;
            default: wb_val = val_reg;
        endcase
    end

    assign wr_en = (is_alu || is_load) && rt_reg != REG_ZERO;

    always_comb begin
        mem_cmd.rd    = (state_reg == S_MEM) && is_load;
        mem_cmd.wr    = (state_reg == S_MEM) && is_store;
        case (k_reg)
            2'd0:    mem_cmd.wdata = b_reg[7:0];
            2'd1:    mem_cmd.wdata = b_reg[15:8];
            2'd2:    mem_cmd.wdata = b_reg[23:16];
            default: mem_cmd.wdata = b_reg[31:24];
        endcase
    end

    assign rf_wr.en   = (state_reg == S_WB) && out_free && wr_en;
    assign rf_wr.idx  = rt_reg;
    assign rf_wr.data = wb_val;

    always_comb begin
        state_next = state_reg;
        npc_next   = npc_reg;
        taken_next = taken_reg;
        val_next   = val_reg;
        ea_next    = ea_reg;
        mod_next   = mod_reg;
        addr_next  = addr_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                taken_next = (op_reg == OP_BEQ && rd_a == rd_b) ||
                             (op_reg == OP_BNE && rd_a != rd_b);
                npc_next   = taken_next ? pc4_reg + br_off : pc4_reg;
                val_next   = alu_res;
                ea_next    = alu_res;
                b_next     = rd_b;
                k_next     = 2'd0;
                step_next  = 2'd0;
                addr_next  = alu_res[AW-1:0];
                if (is_load || is_store) begin
                    state_next = MEM_POW2 ? S_MEM : S_MOD;
                end else begin
                    state_next = S_WB;
                end
            end
            S_MOD: begin
                // quotient by reciprocal multiply, remainder, then one compare and subtract
                step_next = step_reg + 1'b1;
                case (step_reg)
                    2'd0:    mod_next = 32'(mod_prod >> MOD_SHIFT);
                    2'd1:    mod_next = ea_reg - mod_reg * MOD_DIV;
                    default: begin
                        addr_next  = (mod_reg >= MOD_DIV) ? AW'(mod_reg - MOD_DIV)
                                                          : AW'(mod_reg);
                        state_next = S_MEM;
                    end
                endcase
            end
            S_MEM: begin
                // byte address wraps at the memory size, and also where the effective address wraps at 2^32
                addr_next = (addr_reg == MEM_LAST || ea_reg == 32'hFFFF_FFFF) ? '0
                                                                              : addr_reg + 1'b1;
                ea_next   = ea_reg + 32'd1;
                k_next    = k_reg + 1'b1;
                if (k_reg == last_k) begin
                    state_next = is_load ? S_LWAIT : S_WB;
                end
            end
            S_LWAIT: state_next = S_WB;
            S_WB: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_cmd.rd;
        end
    end

    always_ff @(posedge aclk) begin
        npc_reg   <= npc_next;
        taken_reg <= taken_next;
        val_reg   <= val_next;
        ea_reg    <= ea_next;
        mod_reg   <= mod_next;
        addr_reg  <= addr_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
        step_reg  <= step_next;
        rd_k_reg  <= k_reg;
        if (accept) begin
            op_reg  <= s_tdata[31:26];
            rt_reg  <= s_tdata[20:16];
            imm_reg <= s_tdata[15:0];
            pc4_reg <= s_tdata[63:32] + 32'd4;
        end
        if (state_reg == S_EXEC) begin
            ld_reg <= '0;
        end else if (rd_pend_reg) begin
            case (rd_k_reg)
                2'd0:    ld_reg[7:0]   <= mem_rdata;
                2'd1:    ld_reg[15:8]  <= mem_rdata;
                2'd2:    ld_reg[23:16] <= mem_rdata;
                default: ld_reg[31:24] <= mem_rdata;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_WB && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_WB && out_free) begin
            m_tdata_reg <= {1'b0,
                            wr_en ? wb_val : 32'd0,
                            wr_en ? rt_reg : REG_ZERO,
                            wr_en,
                            taken_reg,
                            npc_reg};
            m_tuser_reg <= illegal;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "mips_itype_execute_core_assert.svh"

    `MITE_ASSERT_IMPL(a_no_accept_while_clearing, aclk, aresetn, mem_busy, !s_tready)
    `MITE_ASSERT_IMPL(a_no_write_reg_zero, aclk, aresetn, rf_wr.en, rf_wr.idx != REG_ZERO)
    `MITE_ASSERT_NEXT(a_accept_starts_exec, aclk, aresetn, accept, state_reg == S_EXEC)
    `MITE_ASSERT_IMPL(a_mem_only_in_mem_state, aclk, aresetn, mem_cmd.wr || mem_cmd.rd, state_reg == S_MEM && !mem_busy)

endmodule

### sim/tb_mips_itype_execute_core.sv
`timescale 1ns / 1ps
// testbench for mips_itype_execute_core: directed and random i-type instructions, each
// result checked against a scoreboard that predicts the register file and data memory
// depends on mite_pkg and the core rtl
module tb_mips_itype_execute_core;
    import mite_pkg::*;

    localparam int          MEM_BYTES  = 4096;
    localparam logic [31:0] MEM_SIZE   = 32'd4096;
    localparam int          N_RANDOM   = 1800;
    localparam logic [5:0]  OP_SPECIAL = 6'h00;
    localparam logic [5:0]  OP_UNUSED  = 6'h3F;
    localparam logic [5:0]  LEGAL_OPS [18] = '{
        OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
        OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW
    };

    typedef struct {
        logic [31:0] next_pc;
        logic        taken;
        logic        written;
        logic [4:0]  index;
        logic [31:0] value;
        logic        illegal;
    } outcome_t;

    class itype_checker;
        logic [31:0] gpr [32];
        logic [7:0]  dmem [MEM_BYTES];
        outcome_t    pending [$];
        int          errors;
        int          checked;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [31:0] load_bytes(logic [31:0] ea, int n);
            logic [31:0] v;
            logic [31:0] addr;
            int          k;
            v = '0;
            for (k = 0; k < n; k++) begin
                addr = ea + k;
                v[8*k +: 8] = dmem[addr % MEM_SIZE];
            end
            return v;
        endfunction

        function void store_bytes(logic [31:0] ea, int n, logic [31:0] v);
            logic [31:0] addr;
            int          k;
            for (k = 0; k < n; k++) begin
                addr = ea + k;
                dmem[addr % MEM_SIZE] = v[8*k +: 8];
            end
        endfunction

        function void note_insn(logic [31:0] insn, logic [31:0] pc);
            logic [5:0]  op;
            logic [4:0]  rs;
            logic [4:0]  rt;
            logic [15:0] imm;
            logic [31:0] simm;
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] ea;
            logic [31:0] v;
            logic        wr;
            outcome_t    e;
            op   = insn[31:26];
            rs   = insn[25:21];
            rt   = insn[20:16];
            imm  = insn[15:0];
            simm = {{16{imm[15]}}, imm};
            a    = gpr[rs];
            b    = gpr[rt];
            ea   = a + simm;
            v    = '0;
            wr   = 1'b0;
            e.next_pc = pc + 32'd4;
            e.taken   = 1'b0;
            e.illegal = 1'b0;
            case (op)
                OP_ADDI, OP_ADDIU: begin
                    v  = a + simm;
                    wr = 1'b1;
                end
                OP_SLTI: begin
                    v  = {31'd0, $signed(a) < $signed(simm)};
                    wr = 1'b1;
                end
                OP_SLTIU: begin
                    v  = {31'd0, a < simm};
                    wr = 1'b1;
                end
                OP_ANDI: begin
                    v  = a & {16'd0, imm};
                    wr = 1'b1;
                end
                OP_ORI: begin
                    v  = a | {16'd0, imm};
                    wr = 1'b1;
                end
                OP_XORI: begin
                    v  = a ^ {16'd0, imm};
                    wr = 1'b1;
                end
                OP_LUI: begin
                    v  = {imm, 16'd0};
                    wr = 1'b1;
                end
                OP_BEQ: e.taken = (a == b);
                OP_BNE: e.taken = (a != b);
                OP_LB: begin
                    v  = load_bytes(ea, 1);
                    v  = {{24{v[7]}}, v[7:0]};
                    wr = 1'b1;
                end
                OP_LBU: begin
                    v  = load_bytes(ea, 1);
                    wr = 1'b1;
                end
                OP_LH: begin
                    v  = load_bytes(ea, 2);
                    v  = {{16{v[15]}}, v[15:0]};
                    wr = 1'b1;
                end
                OP_LHU: begin
                    v  = load_bytes(ea, 2);
                    wr = 1'b1;
                end
                OP_LW: begin
                    v  = load_bytes(ea, 4);
                    wr = 1'b1;
                end
                OP_SB: store_bytes(ea, 1, b);
                OP_SH: store_bytes(ea, 2, b);
                OP_SW: store_bytes(ea, 4, b);
                default: e.illegal = 1'b1;
            endcase
            if (e.taken)
                e.next_pc = pc + 32'd4 + {simm[29:0], 2'b00};
            if (rt == REG_ZERO)
                wr = 1'b0;
            if (wr)
                gpr[rt] = v;
            e.written = wr;
            e.index   = wr ? rt : REG_ZERO;
            e.value   = wr ? v : 32'd0;
            pending.push_back(e);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_outcome(logic [71:0] d, logic u);
            outcome_t e;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("result %0d with no instruction pending", checked));
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.next_pc)
                report($sformatf("item %0d next_pc %h want %h", checked, d[31:0], e.next_pc));
            if (d[32] !== e.taken)
                report($sformatf("item %0d branch_taken %b want %b", checked, d[32], e.taken));
            if (d[33] !== e.written)
                report($sformatf("item %0d dest_written %b want %b", checked, d[33], e.written));
            if (d[38:34] !== e.index)
                report($sformatf("item %0d dest_index %0d want %0d", checked, d[38:34], e.index));
            if (d[70:39] !== e.value)
                report($sformatf("item %0d dest_value %h want %h", checked, d[70:39], e.value));
            if (u !== e.illegal)
                report($sformatf("item %0d illegal_opcode %b want %b", checked, u, e.illegal));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;
    bit          calm;
    itype_checker sb;

    mips_itype_execute_core #(
        .MEM_BYTES(MEM_BYTES)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [31:0] enc(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] make_insn();
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        int          r;
        bit          legal;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom();
        op = LEGAL_OPS[$urandom_range(0, 17)];
        if (r < 10) begin
            do begin
                op    = 6'($urandom());
                legal = 1'b0;
                foreach (LEGAL_OPS[i])
                    if (LEGAL_OPS[i] == op)
                        legal = 1'b1;
            end while (legal);
        end
        rs  = 5'($urandom());
        rt  = 5'($urandom());
        imm = 16'($urandom());
        // a few hot registers so values flow between instructions
        if ($urandom_range(0, 1)) begin
            rs = 5'($urandom_range(0, 7));
            rt = 5'($urandom_range(0, 7));
        end
        // addresses around the memory wrap point so loads see earlier stores
        if (op >= OP_LB && $urandom_range(0, 1)) begin
            rs  = REG_ZERO;
            imm = 16'($urandom_range(0, 127)) - 16'd64;
        end
        if ((op == OP_BEQ || op == OP_BNE) && $urandom_range(0, 2) == 0)
            rt = rs;
        return {op, rs, rt, imm};
    endfunction

    task automatic send_insn(logic [31:0] insn, logic [31:0] pc);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pc, insn};
        do @(posedge aclk); while (!s_tready);
        sb.note_insn(insn, pc);
    endtask

    // result side: random stalls plus one long hold-off to back the core up
    initial begin
        int stall_left;
        int hold_left;
        bit held;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_outcome(m_tdata, m_tuser);
            if (hold_left > 0)
                hold_left--;
            else if (!held && sb.checked >= 300) begin
                held      = 1'b1;
                hold_left = 250;
            end else if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap();
            m_tready <= aresetn && hold_left == 0 && stall_left == 0;
        end
    end

    initial begin
        int n;
        sb = new();
        calm = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_insn(enc(OP_LUI, REG_ZERO, 5'd1, 16'h8000), 32'h0000_0000);
        send_insn(enc(OP_ADDI, REG_ZERO, 5'd2, 16'hFFFF), 32'h0000_0004);
        send_insn(enc(OP_ADDIU, 5'd1, 5'd3, 16'hFFFF), $urandom());
        send_insn(enc(OP_ADDI, 5'd3, 5'd4, 16'h0001), $urandom());
        send_insn(enc(OP_SLTI, 5'd1, 5'd5, 16'h0000), $urandom());
        send_insn(enc(OP_SLTIU, 5'd3, 5'd6, 16'hFFFF), $urandom());
        send_insn(enc(OP_SLTIU, 5'd2, 5'd7, 16'h8000), $urandom());
        send_insn(enc(OP_ANDI, 5'd2, 5'd8, 16'hFFFF), $urandom());
        send_insn(enc(OP_ORI, REG_ZERO, 5'd9, 16'h8000), $urandom());
        send_insn(enc(OP_XORI, 5'd2, 5'd10, 16'hFFFF), $urandom());
        send_insn(enc(OP_ADDI, 5'd2, REG_ZERO, 16'h0005), $urandom());
        send_insn(enc(OP_SW, REG_ZERO, 5'd3, 16'hFFFF), $urandom());
        send_insn(enc(OP_LB, REG_ZERO, 5'd11, 16'h0001), $urandom());
        send_insn(enc(OP_LB, REG_ZERO, 5'd12, 16'h0002), $urandom());
        send_insn(enc(OP_LBU, REG_ZERO, 5'd13, 16'h0001), $urandom());
        send_insn(enc(OP_SH, REG_ZERO, 5'd9, 16'h0FFF), $urandom());
        send_insn(enc(OP_LH, REG_ZERO, 5'd14, 16'hFFFF), $urandom());
        send_insn(enc(OP_LHU, REG_ZERO, 5'd15, 16'hFFFF), $urandom());
        send_insn(enc(OP_SB, REG_ZERO, 5'd2, 16'h0003), $urandom());
        send_insn(enc(OP_LW, 5'd1, 5'd16, 16'h0000), $urandom());
        send_insn(enc(OP_LW, REG_ZERO, 5'd17, 16'hFFFF), $urandom());
        send_insn(enc(OP_BEQ, 5'd1, 5'd4, 16'h7FFF), 32'hFFFF_FFF0);
        send_insn(enc(OP_BEQ, 5'd1, 5'd2, 16'h7FFF), 32'hFFFF_FFFC);
        send_insn(enc(OP_BNE, 5'd1, 5'd2, 16'h8000), 32'h0000_0010);
        send_insn(enc(OP_BNE, REG_ZERO, REG_ZERO, 16'h8000), 32'h0000_0000);
        send_insn(enc(OP_UNUSED, 5'd31, 5'd31, 16'hFFFF), 32'hFFFF_FFFC);
        send_insn(enc(OP_SPECIAL, REG_ZERO, REG_ZERO, 16'h0000), 32'h0000_0000);
        send_insn(enc(OP_LUI, 5'd31, 5'd31, 16'hFFFF), 32'hFFFF_FFFF);

        for (n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 600 && n < 800);
            send_insn(make_insn(), $urandom());
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
